// ----- rtl/core/rfde_pkg.sv -----
package rfde_pkg;

  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int StoreBytes = MaxWidth * MaxHeight * 3;
  localparam int AddrW = $clog2(StoreBytes);
  localparam int WordAddrW = $clog2(StoreBytes / 2 + 1);
  localparam int DimW = 9;
  localparam int QDepth = 4;

  localparam logic [2:0] OP_SET     = 3'd0;
  localparam logic [2:0] OP_GET     = 3'd1;
  localparam logic [2:0] OP_FILL    = 3'd2;
  localparam logic [2:0] OP_OUTLINE = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [1:0] REG_ROTATION = 2'd0;
  localparam logic [1:0] REG_MODE     = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;
  localparam logic [1:0] REG_HEIGHT   = 2'd3;

  localparam logic [2:0] MODE_RGB565LE = 3'd0;
  localparam logic [2:0] MODE_RGB565BE = 3'd1;
  localparam logic [2:0] MODE_BGR565LE = 3'd2;
  localparam logic [2:0] MODE_BGR565BE = 3'd3;
  localparam logic [2:0] MODE_RGB888   = 3'd4;
  localparam logic [2:0] MODE_BGR888   = 3'd5;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [11:0] x_pos;
    logic signed [11:0] y_pos;
    logic signed [11:0] rect_width;
    logic signed [11:0] rect_height;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
  } rsp_t;

  // One pixel operation for the back end.
  typedef struct packed {
    logic        is_get;
    logic        valid_pt;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pix_t;

endpackage

// ----- rtl/core/rotated_framebuffer_draw_engine.sv -----
// A get's result transfers once its command has passed the queue, the rotation and
// pixel-index stages and the registered store read. Commands go one at a time; busy
// holds until the queue and back end drain. Fill, outline and clear step one point a
// cycle while the queue is not full (in 888 modes the third-byte write holds back the
// queue's pop); outline edges once per side. Reset: synchronous; the pixel store is swept
// to zero after reset while busy stays high. Results cannot be stalled by the receiver.
module rotated_framebuffer_draw_engine import rfde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  cmd_t       cmd,
  output logic       busy,
  output logic       result_valid,
  output rsp_t       result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);
  logic [1:0] rotation;
  logic [2:0] color_mode;
  logic [8:0] panel_width, panel_height;
  logic [DimW-1:0] eff_w, eff_h, view_w, view_h;

  // clamp the panel to the store size, swap for quarter turns
  assign eff_w  = (panel_width  > DimW'(MaxWidth))  ? DimW'(MaxWidth)  : panel_width;
  assign eff_h  = (panel_height > DimW'(MaxHeight)) ? DimW'(MaxHeight) : panel_height;
  assign view_w = rotation[0] ? eff_h : eff_w;
  assign view_h = rotation[0] ? eff_w : eff_h;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= '0; color_mode <= '0;
      panel_width <= 9'd256; panel_height <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROTATION: rotation <= cfg_data[1:0];
        REG_MODE:     color_mode <= cfg_data[2:0];
        REG_WIDTH:    panel_width <= cfg_data;
        REG_HEIGHT:   panel_height <= cfg_data;
        default:      rotation <= rotation;
      endcase
    end
  end

  logic q_full, q_empty, q_push, q_pop, back_idle, front_busy;
  pix_t q_in, q_out;

  // the front end only sees a transfer the top level accepts
  rfde_front u_front (
    .clk, .rst, .start(start && !busy), .cmd, .busy(front_busy),
    .view_w, .view_h, .q_full, .q_push, .q_data(q_in)
  );

  rfde_queue u_queue (
    .clk, .rst, .push(q_push), .din(q_in), .full(q_full), .empty(q_empty),
    .pop(q_pop), .dout(q_out)
  );

  rfde_back u_back (
    .clk, .rst, .q_empty, .q_data(q_out), .q_pop, .idle(back_idle),
    .rotation, .color_mode, .eff_w, .eff_h, .result_valid, .result
  );

  // hold off commands while the store is being cleared after reset
  logic clr_done;
  always_ff @(posedge clk) begin
    if (rst) clr_done <= 1'b0;
    else if (back_idle) clr_done <= 1'b1;
  end
  // hold each command until every earlier pixel has drained through the back end
  assign busy = front_busy || !clr_done || !back_idle || !q_empty;
endmodule

// ----- rtl/core/rfde_front.sv -----
module rfde_front import rfde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  cmd_t       cmd,
  output logic       busy,
  input  logic [DimW-1:0] view_w,
  input  logic [DimW-1:0] view_h,
  input  logic       q_full,
  output logic       q_push,
  output pix_t       q_data
);
  // Walk generator: spans are clipped and stepped one pixel a cycle if !q_full.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RECT = 2'd1;
  localparam logic [1:0] ST_COLS = 2'd2;
  localparam logic [1:0] ST_ROWS = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  cmd_t       c;
  logic signed [13:0] ix, iy, x_end, y_end, y_beg;
  logic signed [13:0] ex, ey;
  logic       second;
  logic signed [13:0] sx, sy, sw, sh, vw, vh;

  assign sx = 14'(cmd.x_pos);
  assign sy = 14'(cmd.y_pos);
  assign sw = 14'(cmd.rect_width);
  assign sh = 14'(cmd.rect_height);
  assign vw = 14'(view_w);
  assign vh = 14'(view_h);

  function automatic logic signed [13:0] smax(logic signed [13:0] a, logic signed [13:0] b);
    return (a > b) ? a : b;
  endfunction
  function automatic logic signed [13:0] smin(logic signed [13:0] a, logic signed [13:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic in_v(logic signed [13:0] a, logic signed [13:0] b,
                                logic signed [13:0] w, logic signed [13:0] h);
    return (a >= 0) && (b >= 0) && (a < w) && (b < h);
  endfunction

  logic accept;
  assign busy = (state != ST_IDLE) || q_full;
  assign accept = start && !busy;

  logic signed [13:0] px, py;
  always_comb begin
    q_push = 1'b0;
    px = ix;
    py = iy;
    if (accept && (cmd.op == OP_SET || cmd.op == OP_GET)) begin
      q_push = 1'b1;
      px = sx;
      py = sy;
    end else if (!q_full) begin
      case (state)
        ST_RECT: begin
          q_push = 1'b1;
        end
        ST_COLS: begin
          q_push = 1'b1;
          px = second ? ex : 14'(c.x_pos);
        end
        ST_ROWS: begin
          q_push = 1'b1;
          py = second ? ey : 14'(c.y_pos);
        end
        default: q_push = 1'b0;
      endcase
    end
    q_data.is_get   = accept && (cmd.op == OP_GET);
    q_data.valid_pt = in_v(px, py, vw, vh);
    q_data.vx       = px[7:0];
    q_data.vy       = py[7:0];
    q_data.red      = (state == ST_IDLE) ? cmd.red : c.red;
    q_data.green    = (state == ST_IDLE) ? cmd.green : c.green;
    q_data.blue     = (state == ST_IDLE) ? cmd.blue : c.blue;
  end

  always_comb begin
    state_next = state;
    if (state == ST_IDLE && accept) begin
      if (cmd.op == OP_FILL) begin
        if (smax(sx, 0) < smin(sx + sw, vw) && smax(sy, 0) < smin(sy + sh, vh))
          state_next = ST_RECT;
      end else if (cmd.op == OP_CLEAR) begin
        if (vw > 0 && vh > 0) state_next = ST_RECT;
      end else if (cmd.op == OP_OUTLINE) begin
        if (smax(sy, 0) < smin(sy + sh, vh)) state_next = ST_COLS;
        else if (smax(sx + 1, 0) < smin(sx + sw - 1, vw)) state_next = ST_ROWS;
      end
    end else if (!q_full) begin
      case (state)
        ST_RECT: if (iy + 1 >= y_end && ix + 1 >= x_end) state_next = ST_IDLE;
        ST_COLS: if (second && iy + 1 >= y_end) begin
          if (smax(14'(c.x_pos) + 1, 0) < smin(ex, vw)) state_next = ST_ROWS;
          else state_next = ST_IDLE;
        end
        ST_ROWS: if (second && ix + 1 >= x_end) state_next = ST_IDLE;
        default: state_next = state;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == ST_IDLE && accept) begin
      c <= cmd;
      second <= 1'b0;
      ex <= sx + sw - 14'sd1;
      ey <= sy + sh - 14'sd1;
      if (cmd.op == OP_CLEAR) begin
        ix <= '0; iy <= '0; x_end <= vw; y_end <= vh; y_beg <= '0;
      end else if (cmd.op == OP_FILL) begin
        ix <= smax(sx, 0); iy <= smax(sy, 0);
        x_end <= smin(sx + sw, vw); y_end <= smin(sy + sh, vh);
        y_beg <= smax(sy, 0);
      end else begin
        iy <= smax(sy, 0); y_end <= smin(sy + sh, vh);
        ix <= smax(sx + 1, 0); x_end <= smin(sx + sw - 1, vw);
        y_beg <= smax(sy, 0);
      end
    end else if (!q_full) begin
      case (state)
        ST_RECT: begin
          if (iy + 1 >= y_end) begin
            iy <= y_beg;
            ix <= ix + 14'sd1;
          end else begin
            iy <= iy + 14'sd1;
          end
        end
        ST_COLS: begin
          second <= !second;
          if (second) iy <= iy + 14'sd1;
        end
        ST_ROWS: begin
          second <= !second;
          if (second) ix <= ix + 14'sd1;
        end
        default: second <= second;
      endcase
    end
  end
endmodule

// ----- rtl/core/rfde_queue.sv -----
module rfde_queue import rfde_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pix_t din,
  output logic full,
  output logic empty,
  input  logic pop,
  output pix_t dout
);
  localparam int PtrW = $clog2(QDepth);
  pix_t mem [QDepth];
  logic [PtrW-1:0] wp, rp;
  logic [PtrW:0]   cnt;

  assign full  = (cnt >= (PtrW+1)'(QDepth - 1));
  assign empty = (cnt == '0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
    if (push) mem[wp] <= din;
  end
endmodule

// ----- rtl/core/rfde_back.sv -----
module rfde_back import rfde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  pix_t       q_data,
  output logic       q_pop,
  output logic       idle,
  input  logic [1:0] rotation,
  input  logic [2:0] color_mode,
  input  logic [DimW-1:0] eff_w,
  input  logic [DimW-1:0] eff_h,
  output logic       result_valid,
  output rsp_t       result
);
  // Store holds 16-bit words; a pixel touches at most two words (lo/hi pair).
  localparam int NWords = StoreBytes / 2;
  localparam int WW = $clog2(NWords);
  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;

  logic [7:0] mem_e [NWords];
  logic [7:0] mem_o [NWords];
  logic [1:0] state;
  logic [WW-1:0] clr_addr;

  // stage 1: rotation mapping
  logic       s1_v, s1_get, s1_ok;
  logic [7:0] s1_px, s1_py, s1_r, s1_g, s1_b;
  logic [9:0] px_c, py_c;
  always_comb begin
    case (rotation)
      2'd0: begin px_c = 10'(q_data.vx); py_c = 10'(q_data.vy); end
      2'd1: begin px_c = 10'(eff_w) - 10'(q_data.vy) - 10'd1; py_c = 10'(q_data.vx); end
      2'd2: begin
        px_c = 10'(eff_w) - 10'(q_data.vx) - 10'd1;
        py_c = 10'(eff_h) - 10'(q_data.vy) - 10'd1;
      end
      default: begin px_c = 10'(q_data.vy); py_c = 10'(eff_h) - 10'(q_data.vx) - 10'd1; end
    endcase
  end

  // stage 2: pixel index, stage 3: byte index and write
  logic       s2_v, s2_get, s2_ok;
  logic [16:0] s2_pix;
  logic [7:0] s2_r, s2_g, s2_b;
  logic       s3_get;
  logic [AddrW:0] bidx;
  assign bidx = (color_mode >= MODE_RGB888) ? (AddrW+1)'(s2_pix) * (AddrW+1)'(3)
                                             : (AddrW+1)'(s2_pix) * (AddrW+1)'(2);

  logic [15:0] c565;
  logic [7:0]  cr, cb;
  assign cr = (color_mode >= MODE_BGR565LE) ? s2_b : s2_r;
  assign cb = (color_mode >= MODE_BGR565LE) ? s2_r : s2_b;
  assign c565 = {cr[7:3], s2_g[7:2], cb[7:3]};

  logic [7:0] byt [3];
  always_comb begin
    if (color_mode == MODE_RGB888) begin
      byt[0] = s2_r; byt[1] = s2_g; byt[2] = s2_b;
    end else if (color_mode == MODE_BGR888) begin
      byt[0] = s2_b; byt[1] = s2_g; byt[2] = s2_r;
    end else if (!color_mode[0]) begin
      byt[0] = c565[7:0]; byt[1] = c565[15:8]; byt[2] = 8'd0;
    end else begin
      byt[0] = c565[15:8]; byt[1] = c565[7:0]; byt[2] = 8'd0;
    end
  end

  // byte b lands in bank b[0], word b>>1
  logic [AddrW:0] b0, b1, b2;
  assign b0 = bidx;
  assign b1 = bidx + 1'b1;
  assign b2 = bidx + 2'd2;
  logic mode_ok;
  assign mode_ok = color_mode <= MODE_BGR888;
  logic wr;
  assign wr = s2_v && !s2_get && s2_ok && mode_ok;
  logic three;
  assign three = color_mode >= MODE_RGB888;

  logic [WW-1:0] ea, oa;
  logic [7:0]    ed, od;
  logic          ewe, owe;
  always_comb begin
    ewe = 1'b0; owe = 1'b0;
    ea = WW'(b0 >> 1); oa = WW'(b0 >> 1); ed = byt[0]; od = byt[1];
    if (state == ST_CLR) begin
      ewe = 1'b1; owe = 1'b1; ea = clr_addr; oa = clr_addr; ed = '0; od = '0;
    end else if (wr) begin
      if (!b0[0]) begin
        ewe = 1'b1; owe = 1'b1;
        ea = WW'(b0 >> 1); oa = WW'(b0 >> 1); ed = byt[0]; od = byt[1];
      end else begin
        owe = 1'b1; oa = WW'(b0 >> 1); od = byt[0];
        ewe = 1'b1; ea = WW'(b1 >> 1); ed = byt[1];
        if (three) begin
          od = byt[0];
        end
      end
    end
  end
  // the third byte of an 888 pixel goes to its bank next cycle
  logic       pend;
  logic [WW-1:0] pend_a;
  logic [7:0] pend_d;
  logic       pend_e;

  // reads
  logic [7:0] rd_e0, rd_o0, rd_e1, rd_o1;
  logic       g_ok, g_odd;
  logic [2:0] g_mode;

  assign idle = (state != ST_CLR) && !s1_v && !s2_v && !s3_get && !pend;
  assign q_pop = !q_empty && (state == ST_RUN) && !pend && !(s2_v && wr && three);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR; clr_addr <= '0;
      s1_v <= 1'b0; s2_v <= 1'b0; s3_get <= 1'b0; pend <= 1'b0;
    end else begin
      if (state == ST_CLR) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == WW'(NWords - 1)) state <= ST_RUN;
      end
      s1_v <= q_pop;
      s2_v <= s1_v;
      s3_get <= s2_v && s2_get;
      pend <= 1'b0;
      if (wr && three) begin
        pend <= 1'b1;
        pend_e <= !b2[0];
        pend_a <= WW'(b2 >> 1);
        pend_d <= byt[2];
      end
    end
    s1_get <= q_data.is_get; s1_ok <= q_data.valid_pt;
    s1_px <= px_c[7:0]; s1_py <= py_c[7:0];
    s1_r <= q_data.red; s1_g <= q_data.green; s1_b <= q_data.blue;
    s2_get <= s1_get; s2_ok <= s1_ok;
    s2_pix <= 17'(s1_px) + 17'(s1_py) * 17'(eff_w);
    s2_r <= s1_r; s2_g <= s1_g; s2_b <= s1_b;
    if (ewe) mem_e[ea] <= ed;
    if (owe) mem_o[oa] <= od;
    if (pend && pend_e) mem_e[pend_a] <= pend_d;
    if (pend && !pend_e) mem_o[pend_a] <= pend_d;
    rd_e0 <= mem_e[WW'(b0 >> 1)];
    rd_o0 <= mem_o[WW'(b0 >> 1)];
    rd_e1 <= mem_e[WW'(b2 >> 1)];
    rd_o1 <= mem_o[WW'(b0 >> 1) + 1'b1];
    g_ok <= s2_ok && mode_ok; g_odd <= b0[0]; g_mode <= color_mode;
  end

  logic [7:0] gb0, gb1, gb2;
  logic [15:0] gc;
  always_comb begin
    gb0 = g_odd ? rd_o0 : rd_e0;
    gb1 = g_odd ? rd_e1 : rd_o0;
    gb2 = g_odd ? rd_o1 : rd_e1;
    gc  = g_mode[0] ? {gb0, gb1} : {gb1, gb0};
    result = '0;
    if (g_ok) begin
      if (g_mode == MODE_RGB888) begin
        result = {gb0, gb1, gb2};
      end else if (g_mode == MODE_BGR888) begin
        result = {gb2, gb1, gb0};
      end else if (g_mode >= MODE_BGR565LE) begin
        result = {gc[4:0], 3'd0, gc[10:5], 2'd0, gc[15:11], 3'd0};
      end else begin
        result = {gc[15:11], 3'd0, gc[10:5], 2'd0, gc[4:0], 3'd0};
      end
    end
  end
  assign result_valid = s3_get;
endmodule

// ----- rtl/core/rfde_checker.sv -----
module rfde_checker import rfde_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input cmd_t cmd,
  input logic busy,
  input logic result_valid,
  input logic cfg_ready
);
  a_busy_after_reset: assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("busy low right after reset");
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config not ready");
  a_no_result_in_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result after reset");
  a_get_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.op == OP_GET) |-> ##4 result_valid)
    else $error("get not answered in time");
endmodule

bind rotated_framebuffer_draw_engine rfde_checker u_checker (
  .clk, .rst, .start, .cmd, .busy, .result_valid, .cfg_ready
);
